[rtl/cmca_pkg.sv]
// Shared types and constants for the capacitated min-cost assignment block.
package cmca_pkg;

    localparam int MAX_TEAMS     = 8;
    localparam int MAX_INCIDENTS = 16;
    localparam int MAX_DIM       = 16;
    localparam int INF_COST      = 16777216;
    localparam int COST_BITS     = 20;

    localparam int TEAM_W  = 3;
    localparam int INC_W   = 4;
    localparam int UNITS_W = 5;
    localparam int TOTAL_W = 24;
    localparam int ROW_W   = 4;
    localparam int DIM_W   = 5;
    localparam int ADDR_W  = TEAM_W + INC_W;
    localparam int WORD_W  = COST_BITS + 1;
    localparam int VAL_W   = 34;

    localparam logic [1:0] OP_LOAD_COST  = 2'd0;
    localparam logic [1:0] OP_LOAD_UNITS = 2'd1;
    localparam logic [1:0] OP_SOLVE      = 2'd2;

    typedef logic signed [VAL_W-1:0] val_t;

    localparam val_t BIG_COST  = val_t'(INF_COST / 4);
    localparam val_t SLACK_INF = val_t'(64'h7FFF_FFFF);

    typedef struct packed {
        logic               run;
        logic               unit_we;
        logic [TEAM_W-1:0]  unit_team;
        logic [UNITS_W-1:0] units;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXPAND,
        S_PREP,
        S_ROW_INIT,
        S_STEP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_UPDATE,
        S_AUG,
        S_MAP,
        S_OUT_RD,
        S_OUT_CHK,
        S_FLUSH
    } state_t;

endpackage

[rtl/cmca_cost_ram.sv]
// Cost matrix memory: one write port, one registered read port.
module cmca_cost_ram #(
    parameter int AW = 7,
    parameter int DW = 21
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/cmca_solver.sv]
// Row expansion, potential-based Hungarian search and result sequencing.
module cmca_solver (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cmca_pkg::cmd_t                     cmd,
    input  logic [3:0]                         team_count,
    input  logic [4:0]                         incident_count,
    output logic [cmca_pkg::ADDR_W-1:0]        raddr,
    input  logic [cmca_pkg::WORD_W-1:0]        rdata,
    output logic                               busy,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cmca_pkg::TEAM_W-1:0]        pair_team,
    output logic [cmca_pkg::INC_W-1:0]         pair_incident,
    output logic [cmca_pkg::COST_BITS-1:0]     pair_cost,
    output logic [cmca_pkg::TOTAL_W-1:0]       cost_sum,
    output logic                               pair_valid,
    output logic                               row_overflow,
    output logic                               last
);
    import cmca_pkg::*;

    state_t state_reg, state_next;

    logic [UNITS_W-1:0] units_reg [MAX_TEAMS];
    logic [TEAM_W-1:0]  owner_reg [MAX_DIM];
    val_t               u_reg     [MAX_DIM+1];
    val_t               v_reg     [MAX_DIM+1];
    val_t               slack_reg [MAX_DIM+1];
    logic [DIM_W-1:0]   match_reg [MAX_DIM+1];
    logic [DIM_W-1:0]   link_reg  [MAX_DIM+1];
    logic [DIM_W-1:0]   rowcol_reg[MAX_DIM+1];
    logic [MAX_DIM:0]   used_reg;

    logic [3:0]         nt_reg;
    logic [DIM_W-1:0]   ni_reg, nr_reg, n_reg;
    logic [3:0]         team_reg;
    logic [UNITS_W-1:0] ucnt_reg;
    logic               ovf_reg;
    logic [DIM_W-1:0]   i_reg, i0_reg, j_reg, j0_reg, j1_reg, c_reg;
    val_t               delta_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic                 pend_valid_reg;
    logic [TEAM_W-1:0]    pend_team_reg;
    logic [INC_W-1:0]     pend_inc_reg;
    logic [COST_BITS-1:0] pend_cost_reg;
    logic [TOTAL_W-1:0]   pend_total_reg;

    logic                 out_valid_reg;
    logic [TEAM_W-1:0]    out_team_reg;
    logic [INC_W-1:0]     out_inc_reg;
    logic [COST_BITS-1:0] out_cost_reg;
    logic [TOTAL_W-1:0]   out_total_reg;
    logic                 out_pv_reg, out_ovf_reg, out_last_reg;

    logic               slot_free;
    logic [DIM_W-1:0]   srow, scol;
    logic [UNITS_W-1:0] u_eff;
    logic [3:0]         nt_clamp;
    logic [DIM_W-1:0]   ni_clamp;
    val_t               entry_val, cur, sl;
    logic [DIM_W-1:0]   oc;
    logic               step_last, exp_last_row, exp_done;

    assign slot_free = !out_valid_reg || !out_stall;
    assign srow      = i0_reg - DIM_W'(1);
    assign scol      = j_reg - DIM_W'(1);
    assign u_eff     = (units_reg[team_reg[TEAM_W-1:0]] == '0) ? UNITS_W'(1)
                                                             : units_reg[team_reg[TEAM_W-1:0]];
    assign nt_clamp  = (team_count > 4'(MAX_TEAMS)) ? 4'(MAX_TEAMS) : team_count;
    assign ni_clamp  = (incident_count > 5'(MAX_DIM)) ? 5'(MAX_DIM) : incident_count;
    assign exp_last_row = (ucnt_reg + UNITS_W'(1) == u_eff);
    assign exp_done  = exp_last_row && (team_reg + 4'd1 == nt_reg);
    assign oc        = rowcol_reg[i_reg + DIM_W'(1)];
    assign step_last = (j_reg == n_reg);

    // cost of padded cell (srow, scol)
    always_comb
    begin
        if (srow < nr_reg && scol < ni_reg)
        begin
            entry_val = rdata[COST_BITS] ? BIG_COST : val_t'(rdata[COST_BITS-1:0]);
        end
        else if (scol >= ni_reg)
        begin
            entry_val = '0;
        end
        else
        begin
            entry_val = BIG_COST;
        end
        cur = entry_val - u_reg[i0_reg] - v_reg[j_reg];
        sl  = (cur < slack_reg[j_reg]) ? cur : slack_reg[j_reg];
    end

    // result address is held while the check waits for the output slot
    always_comb
    begin
        raddr = {owner_reg[srow[ROW_W-1:0]], scol[INC_W-1:0]};
        if (state_reg == S_OUT_RD || state_reg == S_OUT_CHK)
        begin
            raddr = {owner_reg[i_reg[ROW_W-1:0]], INC_W'(oc - DIM_W'(1))};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.run)
                begin
                    state_next = (nt_clamp == '0 || ni_clamp == '0) ? S_FLUSH : S_EXPAND;
                end
            end
            S_EXPAND:   state_next = exp_done ? S_PREP : S_EXPAND;
            S_PREP:     state_next = S_ROW_INIT;
            S_ROW_INIT: state_next = S_STEP;
            S_STEP:     state_next = S_SCAN_RD;
            S_SCAN_RD:  state_next = S_SCAN_CMP;
            S_SCAN_CMP: state_next = step_last ? S_UPDATE : S_SCAN_RD;
            S_UPDATE:
            begin
                if (step_last)
                begin
                    state_next = (match_reg[j1_reg] == '0) ? S_AUG : S_STEP;
                end
            end
            S_AUG:
            begin
                if (link_reg[j0_reg] == '0)
                begin
                    state_next = (i_reg == n_reg) ? S_MAP : S_ROW_INIT;
                end
            end
            S_MAP:      state_next = step_last ? S_OUT_RD : S_MAP;
            S_OUT_RD:
            begin
                if (i_reg == nr_reg)
                begin
                    state_next = S_FLUSH;
                end
                else if (oc != '0 && oc - DIM_W'(1) < ni_reg)
                begin
                    state_next = S_OUT_CHK;
                end
            end
            S_OUT_CHK:
            begin
                if (rdata[COST_BITS] || !pend_valid_reg || slot_free)
                begin
                    state_next = S_OUT_RD;
                end
            end
            S_FLUSH:    state_next = slot_free ? S_IDLE : S_FLUSH;
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy          = (state_reg != S_IDLE);
        out_valid     = out_valid_reg;
        pair_team     = out_team_reg;
        pair_incident = out_inc_reg;
        pair_cost     = out_cost_reg;
        cost_sum      = out_total_reg;
        pair_valid    = out_pv_reg;
        row_overflow  = out_ovf_reg;
        last          = out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT_CHK && !rdata[COST_BITS] && pend_valid_reg && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (state_reg == S_FLUSH && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_OUT_CHK && !rdata[COST_BITS] && (!pend_valid_reg || slot_free))
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (state_reg == S_FLUSH && slot_free)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (cmd.unit_we)
        begin
            units_reg[cmd.unit_team] <= cmd.units;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                nt_reg    <= nt_clamp;
                ni_reg    <= ni_clamp;
                nr_reg    <= '0;
                team_reg  <= '0;
                ucnt_reg  <= '0;
                ovf_reg   <= 1'b0;
                total_reg <= '0;
            end
            S_EXPAND:
            begin
                if (nr_reg < DIM_W'(MAX_DIM))
                begin
                    owner_reg[nr_reg[ROW_W-1:0]] <= team_reg[TEAM_W-1:0];
                    nr_reg <= nr_reg + DIM_W'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                if (exp_last_row)
                begin
                    ucnt_reg <= '0;
                    team_reg <= team_reg + 4'd1;
                end
                else
                begin
                    ucnt_reg <= ucnt_reg + UNITS_W'(1);
                end
            end
            S_PREP:
            begin
                n_reg <= (nr_reg > ni_reg) ? nr_reg : ni_reg;
                i_reg <= DIM_W'(1);
                for (int k = 0; k <= MAX_DIM; k++)
                begin
                    u_reg[k]     <= '0;
                    v_reg[k]     <= '0;
                    match_reg[k] <= '0;
                    link_reg[k]  <= '0;
                end
            end
            S_ROW_INIT:
            begin
                match_reg[0] <= i_reg;
                j0_reg       <= '0;
                used_reg     <= '0;
                for (int k = 0; k <= MAX_DIM; k++)
                begin
                    slack_reg[k] <= SLACK_INF;
                end
            end
            S_STEP:
            begin
                used_reg[j0_reg] <= 1'b1;
                i0_reg    <= match_reg[j0_reg];
                delta_reg <= SLACK_INF;
                j1_reg    <= '0;
                j_reg     <= DIM_W'(1);
            end
            S_SCAN_RD:
            begin
            end
            S_SCAN_CMP:
            begin
                if (!used_reg[j_reg])
                begin
                    if (cur < slack_reg[j_reg])
                    begin
                        slack_reg[j_reg] <= cur;
                        link_reg[j_reg]  <= j0_reg;
                    end
                    if (sl < delta_reg)
                    begin
                        delta_reg <= sl;
                        j1_reg    <= j_reg;
                    end
                end
                j_reg <= step_last ? '0 : j_reg + DIM_W'(1);
            end
            S_UPDATE:
            begin
                if (used_reg[j_reg])
                begin
                    u_reg[match_reg[j_reg]] <= u_reg[match_reg[j_reg]] + delta_reg;
                    v_reg[j_reg] <= v_reg[j_reg] - delta_reg;
                end
                else
                begin
                    slack_reg[j_reg] <= slack_reg[j_reg] - delta_reg;
                end
                j_reg <= j_reg + DIM_W'(1);
                if (step_last)
                begin
                    j0_reg <= j1_reg;
                end
            end
            S_AUG:
            begin
                match_reg[j0_reg] <= match_reg[link_reg[j0_reg]];
                j0_reg <= link_reg[j0_reg];
                if (link_reg[j0_reg] == '0)
                begin
                    i_reg <= i_reg + DIM_W'(1);
                    j_reg <= DIM_W'(1);
                    for (int k = 0; k <= MAX_DIM; k++)
                    begin
                        rowcol_reg[k] <= '0;
                    end
                end
            end
            S_MAP:
            begin
                rowcol_reg[match_reg[j_reg]] <= j_reg;
                j_reg <= j_reg + DIM_W'(1);
                i_reg <= '0;
            end
            S_OUT_RD:
            begin
                c_reg <= oc - DIM_W'(1);
                if (i_reg != nr_reg && !(oc != '0 && oc - DIM_W'(1) < ni_reg))
                begin
                    i_reg <= i_reg + DIM_W'(1);
                end
            end
            S_OUT_CHK:
            begin
                if (rdata[COST_BITS])
                begin
                    i_reg <= i_reg + DIM_W'(1);
                end
                else if (!pend_valid_reg || slot_free)
                begin
                    // the output register only takes a held pair
                    if (pend_valid_reg)
                    begin
                        out_team_reg  <= pend_team_reg;
                        out_inc_reg   <= pend_inc_reg;
                        out_cost_reg  <= pend_cost_reg;
                        out_total_reg <= pend_total_reg;
                        out_pv_reg    <= 1'b1;
                        out_ovf_reg   <= ovf_reg;
                        out_last_reg  <= 1'b0;
                    end
                    pend_team_reg  <= owner_reg[i_reg[ROW_W-1:0]];
                    pend_inc_reg   <= c_reg[INC_W-1:0];
                    pend_cost_reg  <= rdata[COST_BITS-1:0];
                    pend_total_reg <= total_reg + TOTAL_W'(rdata[COST_BITS-1:0]);
                    total_reg      <= total_reg + TOTAL_W'(rdata[COST_BITS-1:0]);
                    i_reg          <= i_reg + DIM_W'(1);
                end
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    out_team_reg  <= pend_valid_reg ? pend_team_reg : '0;
                    out_inc_reg   <= pend_valid_reg ? pend_inc_reg : '0;
                    out_cost_reg  <= pend_valid_reg ? pend_cost_reg : '0;
                    out_total_reg <= pend_valid_reg ? pend_total_reg : '0;
                    out_pv_reg    <= pend_valid_reg;
                    out_ovf_reg   <= ovf_reg;
                    out_last_reg  <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/capacitated_min_cost_assignment.sv]
// Top level: request decode, configuration registers, cost memory and solver.
//
//  channel | direction  | handshake           | contents
//  in      | to block   | in_valid/in_stall   | opcode, team, incident, cost, unreachable, units
//  out     | from block | out_valid/out_stall | pair fields, running sum, flags, last
//  cfg     | to block   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Loads are accepted back to back. A solve stalls the input while it expands the rows
// (zero units count as one) and clears the potentials, then for each row of the N x N square
// runs a setup, search steps (column reads, compares and updates) and the augmenting links;
// then it maps columns to rows, reads each real row, checks each matched pair and closes.
// Reset clears control only; the cost and unit stores hold garbage until loaded.
// A stalled output holds the sequencer at its next result.
module capacitated_min_cost_assignment (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         opcode,
    input  logic [cmca_pkg::TEAM_W-1:0]        team,
    input  logic [cmca_pkg::INC_W-1:0]         incident,
    input  logic [cmca_pkg::COST_BITS-1:0]     cost,
    input  logic                               unreachable,
    input  logic [cmca_pkg::UNITS_W-1:0]       units,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cmca_pkg::TEAM_W-1:0]        pair_team,
    output logic [cmca_pkg::INC_W-1:0]         pair_incident,
    output logic [cmca_pkg::COST_BITS-1:0]     pair_cost,
    output logic [cmca_pkg::TOTAL_W-1:0]       cost_sum,
    output logic                               pair_valid,
    output logic                               row_overflow,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [4:0]                         cfg_data
);
    import cmca_pkg::*;

    localparam logic REG_TEAM_COUNT     = 1'b0;
    localparam logic REG_INCIDENT_COUNT = 1'b1;

    logic [3:0]        team_count_reg;
    logic [4:0]        incident_count_reg;
    logic              busy, req;
    cmd_t              cmd;
    logic [ADDR_W-1:0] raddr;
    logic [WORD_W-1:0] rdata;

    assign in_stall  = busy;
    assign cfg_ready = 1'b1;
    assign req       = in_valid && !busy;

    assign cmd.run       = req && opcode == OP_SOLVE;
    assign cmd.unit_we   = req && opcode == OP_LOAD_UNITS;
    assign cmd.unit_team = team;
    assign cmd.units     = units;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            team_count_reg     <= '0;
            incident_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TEAM_COUNT:     team_count_reg     <= cfg_data[3:0];
                REG_INCIDENT_COUNT: incident_count_reg <= cfg_data;
                default:            team_count_reg     <= team_count_reg;
            endcase
        end
    end

    cmca_cost_ram #(
        .AW (ADDR_W),
        .DW (WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (req && opcode == OP_LOAD_COST),
        .waddr ({team, incident}),
        .wdata ({unreachable, cost}),
        .raddr (raddr),
        .rdata (rdata)
    );

    cmca_solver u_solver (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .team_count     (team_count_reg),
        .incident_count (incident_count_reg),
        .raddr          (raddr),
        .rdata          (rdata),
        .busy           (busy),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pair_team      (pair_team),
        .pair_incident  (pair_incident),
        .pair_cost      (pair_cost),
        .cost_sum       (cost_sum),
        .pair_valid     (pair_valid),
        .row_overflow   (row_overflow),
        .last           (last)
    );

endmodule

[sim/capacitated_min_cost_assignment_test.sv]
// Testbench for the capacitated min-cost assignment block: directed and randomized loads
// and solves checked against a built-in Hungarian solver.
`timescale 1ns / 100ps

module capacitated_min_cost_assignment_test;
    import cmca_pkg::*;

    localparam logic CFG_TEAMS     = 1'b0;
    localparam logic CFG_INCIDENTS = 1'b1;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint BIG   = INF_COST / 4;
    localparam longint SLACK = 64'h7FFF_FFFF;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [1:0]           op;
        logic [TEAM_W-1:0]    tm;
        logic [INC_W-1:0]     inc;
        logic [COST_BITS-1:0] cst;
        logic                 unr;
        logic [UNITS_W-1:0]   unt;
    } request_t;

    typedef struct {
        logic [TEAM_W-1:0]    tm;
        logic [INC_W-1:0]     inc;
        logic [COST_BITS-1:0] cst;
        logic [TOTAL_W-1:0]   total;
        logic                 valid;
        logic                 ovf;
        logic                 last;
    } pair_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready, cfg_index;
    logic [1:0] opcode;
    logic [TEAM_W-1:0] team, pair_team;
    logic [INC_W-1:0] incident, pair_incident;
    logic [COST_BITS-1:0] cost, pair_cost;
    logic unreachable, pair_valid, row_overflow, last;
    logic [UNITS_W-1:0] units;
    logic [TOTAL_W-1:0] cost_sum;
    logic [4:0] cfg_data;

    capacitated_min_cost_assignment u_top (.*);

    request_t pend_q[$];
    pair_t    plan_q[$];
    int  errors = 0;
    int  cycles = 0;
    int  cfg_hits = 0;
    bit  in_busy = 0;
    bit  calm = 0;

    // solver copy of the block state
    logic [3:0] m_teams;
    logic [4:0] m_incs;
    logic [WORD_W-1:0] m_cost[MAX_TEAMS*MAX_INCIDENTS];
    logic [UNITS_W-1:0] m_units[MAX_TEAMS];
    int m_owner[MAX_DIM];
    longint rp[MAX_DIM+1], cp[MAX_DIM+1], minv[MAX_DIM+1];
    int cm[MAX_DIM+1], bl[MAX_DIM+1];
    bit used[MAX_DIM+1];
    int nrows, nincs;

    // generator bookkeeping: which store entries are defined
    bit cost_seen[MAX_TEAMS*MAX_INCIDENTS];
    bit unit_seen[MAX_TEAMS];

    function automatic longint pad_cost(int i, int j);
        logic [WORD_W-1:0] w;
        if (i < nrows && j < nincs)
        begin
            w = m_cost[m_owner[i]*MAX_INCIDENTS + j];
            return w[COST_BITS] ? BIG : longint'(w[COST_BITS-1:0]);
        end
        if (j >= nincs) return 0;
        return BIG;
    endfunction

    function automatic void hungarian(int n);
        int j0, j1, i0;
        longint delta, cur;
        for (int j = 0; j <= MAX_DIM; j++)
        begin
            rp[j] = 0; cp[j] = 0; cm[j] = 0; bl[j] = 0;
        end
        for (int i = 1; i <= n; i++)
        begin
            j0 = 0;
            cm[0] = i;
            for (int j = 0; j <= n; j++)
            begin
                minv[j] = SLACK; used[j] = 0;
            end
            for (int k = 0; k <= n; k++)
            begin
                used[j0] = 1;
                i0 = cm[j0];
                delta = SLACK;
                j1 = 0;
                for (int j = 1; j <= n; j++)
                begin
                    if (used[j]) continue;
                    cur = pad_cost(i0 - 1, j - 1) - rp[i0] - cp[j];
                    if (cur < minv[j])
                    begin
                        minv[j] = cur; bl[j] = j0;
                    end
                    if (minv[j] < delta)
                    begin
                        delta = minv[j]; j1 = j;
                    end
                end
                for (int j = 0; j <= n; j++)
                begin
                    if (used[j])
                    begin
                        rp[cm[j]] += delta;
                        cp[j] -= delta;
                    end
                    else
                        minv[j] -= delta;
                end
                j0 = j1;
                if (cm[j0] == 0) break;
            end
            for (int k = 0; k <= n; k++)
            begin
                j1 = bl[j0];
                cm[j0] = cm[j1];
                j0 = j1;
                if (j0 == 0) break;
            end
        end
    endfunction

    function automatic void plan_solve();
        int nt, ni, u, n, c, cnt;
        int row_col[MAX_DIM+1];
        logic [WORD_W-1:0] w;
        logic [TOTAL_W-1:0] total;
        bit ovf;
        pair_t p;
        nt = (m_teams > MAX_TEAMS) ? MAX_TEAMS : m_teams;
        ni = (m_incs > MAX_INCIDENTS) ? MAX_INCIDENTS : m_incs;
        nrows = 0; ovf = 0; cnt = 0; total = '0;
        if (nt != 0 && ni != 0)
        begin
            for (int i = 0; i < nt; i++)
            begin
                u = (m_units[i] == 0) ? 1 : m_units[i];
                for (int j = 0; j < u; j++)
                    if (nrows < MAX_DIM) m_owner[nrows++] = i;
                    else ovf = 1;
            end
            nincs = ni;
            n = (nrows > ni) ? nrows : ni;
            hungarian(n);
            foreach (row_col[j]) row_col[j] = 0;
            for (int j = 1; j <= n; j++) row_col[cm[j]] = j;
            for (int i = 0; i < nrows; i++)
            begin
                c = row_col[i+1];
                if (c == 0 || c - 1 >= ni) continue;
                w = m_cost[m_owner[i]*MAX_INCIDENTS + c - 1];
                if (w[COST_BITS]) continue;
                total = total + TOTAL_W'(w[COST_BITS-1:0]);
                p.tm = TEAM_W'(m_owner[i]); p.inc = INC_W'(c - 1); p.cst = w[COST_BITS-1:0];
                p.total = total; p.valid = 1; p.ovf = ovf; p.last = 0;
                plan_q = {plan_q, p};
                cnt++;
            end
        end
        if (cnt == 0)
        begin
            p.tm = '0; p.inc = '0; p.cst = '0; p.total = '0; p.valid = 0; p.ovf = ovf;
            p.last = 1;
            plan_q = {plan_q, p};
        end
        else
            plan_q[plan_q.size()-1].last = 1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
        errors++;
    endtask

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin
        request_t r;
        if (!in_busy)
        begin
            if (rst_n && pend_q.size() > 0 && (calm || $urandom_range(99) >= 20))
            begin
                r = pend_q.pop_front();
                opcode <= r.op; team <= r.tm; incident <= r.inc;
                cost <= r.cst; unreachable <= r.unr; units <= r.unt;
                in_valid <= 1;
                in_busy = 1;
            end
            else
                in_valid <= 0;
        end
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 20);
    end

    // monitor and solver update
    always @(posedge clk)
    begin
        pair_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("capacitated_min_cost_assignment_test failed");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (plan_q.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                e = plan_q.pop_front();
                if (pair_team !== e.tm) report_mismatch("pair_team", pair_team, e.tm);
                if (pair_incident !== e.inc)
                    report_mismatch("pair_incident", pair_incident, e.inc);
                if (pair_cost !== e.cst) report_mismatch("pair_cost", pair_cost, e.cst);
                if (cost_sum !== e.total)
                    report_mismatch("cost_sum", cost_sum, e.total);
                if (pair_valid !== e.valid)
                    report_mismatch("pair_valid", pair_valid, e.valid);
                if (row_overflow !== e.ovf)
                    report_mismatch("row_overflow", row_overflow, e.ovf);
                if (last !== e.last) report_mismatch("last", last, e.last);
            end
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_TEAMS) m_teams = cfg_data[3:0];
            else m_incs = cfg_data;
            cfg_hits++;
        end
        if (rst_n && in_valid && !in_stall)
        begin
            in_busy = 0;
            case (opcode)
                OP_LOAD_COST: m_cost[{team, incident}] = {unreachable, cost};
                OP_LOAD_UNITS: m_units[team] = units;
                OP_SOLVE: plan_solve();
                default: ;
            endcase
        end
    end

    task automatic write_reg(logic idx, logic [4:0] val);
        int n0;
        n0 = cfg_hits;
        @(negedge clk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        while (cfg_hits == n0) @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic wait_drained();
        while (pend_q.size() > 0 || in_busy || plan_q.size() > 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic set_counts(logic [4:0] tc, logic [4:0] ic);
        wait_drained();
        write_reg(CFG_TEAMS, tc);
        write_reg(CFG_INCIDENTS, ic);
    endtask

    function automatic void push_req(logic [1:0] op, int tm, int inc, int cst, bit unr,
                                     int unt);
        request_t r;
        r.op = op; r.tm = TEAM_W'(tm); r.inc = INC_W'(inc); r.cst = COST_BITS'(cst);
        r.unr = unr; r.unt = UNITS_W'(unt);
        if (op == OP_LOAD_COST) cost_seen[tm*MAX_INCIDENTS + inc] = 1;
        if (op == OP_LOAD_UNITS) unit_seen[tm] = 1;
        pend_q = {pend_q, r};
    endfunction

    function automatic int rand_cost();
        case ($urandom_range(9))
            0: return 0;
            1: return (1 << COST_BITS) - 1;
            2, 3: return $urandom_range((1 << COST_BITS) - 1);
            default: return $urandom_range(200);
        endcase
    endfunction

    function automatic int rand_units();
        case ($urandom_range(19))
            0: return 16;
            1: return $urandom_range(16);
            default: return $urandom_range(2);
        endcase
    endfunction

    // a solve may only read defined store entries
    function automatic void push_solve(int tc, int ic);
        int nt, ni;
        nt = (tc > MAX_TEAMS) ? MAX_TEAMS : tc;
        ni = (ic > MAX_INCIDENTS) ? MAX_INCIDENTS : ic;
        if (nt != 0 && ni != 0)
            for (int t = 0; t < nt; t++)
            begin
                if (!unit_seen[t]) push_req(OP_LOAD_UNITS, t, 0, 0, 0, rand_units());
                for (int j = 0; j < ni; j++)
                    if (!cost_seen[t*MAX_INCIDENTS + j])
                        push_req(OP_LOAD_COST, t, j, rand_cost(), $urandom_range(9) == 0,
                                 0);
            end
        push_req(OP_SOLVE, $urandom_range(7), $urandom_range(15), 0, 0, 0);
    endfunction

    initial
    begin
        int tc, ic;
        in_valid = 0; out_stall = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        opcode = 0; team = 0; incident = 0; cost = 0; unreachable = 0; units = 0;
        m_teams = 0; m_incs = 0;
        rst_n = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: small plan with extremes and unreachable pairs
        set_counts(2, 3);
        push_req(OP_LOAD_UNITS, 0, 0, 0, 0, 0);
        push_req(OP_LOAD_UNITS, 1, 0, 0, 0, 2);
        push_req(OP_LOAD_COST, 0, 0, 0, 0, 0);
        push_req(OP_LOAD_COST, 0, 1, (1 << COST_BITS) - 1, 0, 0);
        push_req(OP_LOAD_COST, 0, 2, 5, 1, 0);
        push_req(OP_LOAD_COST, 1, 0, 3, 0, 0);
        push_req(OP_LOAD_COST, 1, 1, 7, 1, 0);
        push_req(OP_LOAD_COST, 1, 2, 9, 0, 0);
        push_req(OP_UNUSED, 7, 15, (1 << COST_BITS) - 1, 1, 31);
        push_solve(2, 3);
        // empty plans: zero teams, zero incidents, all unreachable
        set_counts(0, 5);
        push_solve(0, 5);
        set_counts(3, 0);
        push_solve(3, 0);
        set_counts(1, 1);
        push_req(OP_LOAD_COST, 0, 0, 11, 1, 0);
        push_solve(1, 1);
        // row overflow: sixteen units on one team plus more rows
        set_counts(2, 2);
        push_req(OP_LOAD_UNITS, 0, 0, 0, 0, 16);
        push_solve(2, 2);

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0:
                begin
                    tc = 8; ic = 16;
                end
                1:
                begin
                    tc = 31; ic = 31;
                end
                2:
                begin
                    tc = 1; ic = 16;
                end
                3:
                begin
                    tc = 8; ic = 1;
                end
                4:
                begin
                    tc = 8; ic = 16;
                end
                default:
                begin
                    tc = $urandom_range(15); ic = $urandom_range(31);
                end
            endcase
            set_counts(tc, ic);
            calm = (ph == 4);
            for (int n = 0; n < 2; n++)
            begin
                case ($urandom_range(19))
                    0, 1, 2: push_solve(tc[3:0], ic);
                    3, 4, 5: push_req(OP_LOAD_UNITS, $urandom_range(7), $urandom_range(15),
                                      0, 0, rand_units());
                    6: push_req(OP_UNUSED, $urandom_range(7), $urandom_range(15),
                                $urandom_range((1 << COST_BITS) - 1), $urandom_range(1),
                                $urandom_range(31));
                    default: push_req(OP_LOAD_COST, $urandom_range(7), $urandom_range(15),
                                      rand_cost(), $urandom_range(6) == 0,
                                      $urandom_range(31));
                endcase
            end
            push_solve(tc[3:0], ic);
        end

        wait_drained();
        calm = 0;
        if (errors == 0)
            $display("capacitated_min_cost_assignment_test passed");
        else
            $display("capacitated_min_cost_assignment_test failed");
        $finish;
    end

endmodule
